// ----- src/odc_pkg.sv -----
// Package: shared constants and types for the order discipline checker.
`timescale 1ns / 1ps
package odc_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        V_IMPOSSIBLE = 3'd0,
        V_NOT_SURE   = 3'd1,
        V_QUEUE      = 3'd2,
        V_STACK      = 3'd3,
        V_PRIORITY   = 3'd4
    } verdict_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic                         ins;
        logic                         rem;
        logic                         clr;
        logic signed [DATA_WIDTH-1:0] v;
    } cell_ctrl_t;

endpackage

// ----- src/odc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module odc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/odc_cell.sv -----
// Sorted-chain cell: holds one value of the max-priority queue.
`timescale 1ns / 1ps
module odc_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  odc_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [odc_pkg::DATA_WIDTH-1:0] left_val,
    input  logic                                 left_valid,
    input  logic                                 left_gt,
    input  logic signed [odc_pkg::DATA_WIDTH-1:0] right_val,
    input  logic                                 right_valid,
    output logic signed [odc_pkg::DATA_WIDTH-1:0] val,
    output logic                                 valid,
    output logic                                 gt
);

    logic signed [odc_pkg::DATA_WIDTH-1:0] val_reg;
    logic signed [odc_pkg::DATA_WIDTH-1:0] val_next;
    logic                                  valid_reg;
    logic                                  valid_next;

    assign gt    = !valid_reg || (ctrl.v > val_reg);
    assign val   = val_reg;
    assign valid = valid_reg;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins)
        begin
            valid_next = valid_reg | left_valid;
            if (gt)
            begin
                val_next = left_gt ? left_val : ctrl.v;
            end
        end
        else if (ctrl.rem)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ----- src/order_discipline_checker.sv -----
// Top level: decides queue, stack or priority queue from a trace of transactions.
// The transaction is registered at the accept, where RAM read data lands; the result is
// registered in EXEC, which waits on an unread result. Input is taken only in IDLE.
// The max-priority queue is a sorted chain of cells that all shift together on an insert or remove.
// Reset: asynchronous, active low; clears counters, flags and cell valid bits.
// No clearing pass: RAM contents are only read after being written.
`timescale 1ns / 1ps
module order_discipline_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic signed [31:0] item_value,
    input  logic        case_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic        overflow,
    output logic        trace_done
);

    localparam int DW = odc_pkg::DATA_WIDTH;
    localparam int AW = odc_pkg::ADDR_W;
    localparam int CW = odc_pkg::CNT_W;
    localparam int N  = odc_pkg::DEPTH;

    odc_pkg::state_t   state_reg, state_next;
    logic              op_reg;
    logic signed [DW-1:0] val_reg;
    logic              end_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              fifo_ok_reg, fifo_ok_next;
    logic              lifo_ok_reg, lifo_ok_next;
    logic              heap_ok_reg, heap_ok_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    odc_pkg::verdict_t verdict_reg, verdict_next;
    logic              ovf_out_reg, ovf_out_next;
    logic              done_out_reg, done_out_next;

    logic              in_fire;
    logic              exec_fire;
    logic              full;
    logic              empty;
    logic [CW:0]       wsum;
    logic [AW-1:0]     fifo_waddr;
    logic [AW-1:0]     lifo_raddr;
    logic [DW-1:0]     fifo_rdata;
    logic [DW-1:0]     lifo_rdata;
    logic              do_ins;
    logic              do_rem;
    logic [1:0]        alive;
    odc_pkg::cell_ctrl_t ctrl;

    logic signed [DW-1:0] cell_val   [N];
    logic                 cell_valid [N];
    logic                 cell_gt    [N];

    assign in_ready   = (state_reg == odc_pkg::S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign exec_fire  = (state_reg == odc_pkg::S_EXEC) && (!out_valid_reg || out_ready);
    assign full       = (count_reg >= CW'(N));
    assign empty      = (count_reg == '0);
    assign do_ins     = exec_fire && (op_reg == odc_pkg::OP_INSERT) && !full;
    assign do_rem     = exec_fire && (op_reg == odc_pkg::OP_REMOVE) && !empty;

    assign wsum       = {1'b0, count_reg} + (CW + 1)'(head_reg);
    assign fifo_waddr = (wsum >= (CW + 1)'(N)) ? AW'(wsum - (CW + 1)'(N)) : AW'(wsum);
    assign lifo_raddr = AW'(count_reg - CW'(1));

    assign ctrl.ins = do_ins;
    assign ctrl.rem = do_rem;
    assign ctrl.clr = exec_fire && end_reg;
    assign ctrl.v   = val_reg;

    odc_ram #(.WIDTH(DW), .DEPTH(N)) u_fifo_ram (
        .clk   (clk),
        .we    (do_ins),
        .waddr (fifo_waddr),
        .wdata (val_reg),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    odc_ram #(.WIDTH(DW), .DEPTH(N)) u_lifo_ram (
        .clk   (clk),
        .we    (do_ins),
        .waddr (count_reg[AW-1:0]),
        .wdata (val_reg),
        .raddr (lifo_raddr),
        .rdata (lifo_rdata)
    );

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic signed [DW-1:0] lv, rv;
            logic                 lvalid, lgt, rvalid;
            if (gi == 0)
            begin : g_first
                assign lv     = '0;
                assign lvalid = 1'b1;
                assign lgt    = 1'b0;
            end
            else
            begin : g_mid_l
                assign lv     = cell_val[gi-1];
                assign lvalid = cell_valid[gi-1];
                assign lgt    = cell_gt[gi-1];
            end
            if (gi == N - 1)
            begin : g_last
                assign rv     = '0;
                assign rvalid = 1'b0;
            end
            else
            begin : g_mid_r
                assign rv     = cell_val[gi+1];
                assign rvalid = cell_valid[gi+1];
            end
            odc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_val    (lv),
                .left_valid  (lvalid),
                .left_gt     (lgt),
                .right_val   (rv),
                .right_valid (rvalid),
                .val         (cell_val[gi]),
                .valid       (cell_valid[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fifo_ok_next   = fifo_ok_reg;
        lifo_ok_next   = lifo_ok_reg;
        heap_ok_next   = heap_ok_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        ovf_out_next   = ovf_out_reg;
        done_out_next  = done_out_reg;
        alive          = '0;
        case (state_reg)
            odc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = odc_pkg::S_EXEC;
                end
            end
            odc_pkg::S_EXEC:
            begin
                if (exec_fire)
                begin
                    if (op_reg == odc_pkg::OP_INSERT)
                    begin
                        if (full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (empty)
                    begin
                        fifo_ok_next = 1'b0;
                        lifo_ok_next = 1'b0;
                        heap_ok_next = 1'b0;
                    end
                    else
                    begin
                        if ($signed(fifo_rdata) != val_reg) fifo_ok_next = 1'b0;
                        if ($signed(lifo_rdata) != val_reg) lifo_ok_next = 1'b0;
                        if (cell_val[0] != val_reg)          heap_ok_next = 1'b0;
                        head_next  = (head_reg == AW'(N - 1)) ? '0 : head_reg + AW'(1);
                        count_next = count_reg - CW'(1);
                    end
                    alive = 2'(fifo_ok_next) + 2'(lifo_ok_next) + 2'(heap_ok_next);
                    if (alive == 2'd0)
                        verdict_next = odc_pkg::V_IMPOSSIBLE;
                    else if (alive > 2'd1)
                        verdict_next = odc_pkg::V_NOT_SURE;
                    else if (fifo_ok_next)
                        verdict_next = odc_pkg::V_QUEUE;
                    else if (lifo_ok_next)
                        verdict_next = odc_pkg::V_STACK;
                    else
                        verdict_next = odc_pkg::V_PRIORITY;
                    ovf_out_next   = ovf_next;
                    done_out_next  = end_reg;
                    out_valid_next = 1'b1;
                    state_next     = odc_pkg::S_IDLE;
                    if (end_reg)
                    begin
                        head_next    = '0;
                        count_next   = '0;
                        fifo_ok_next = 1'b1;
                        lifo_ok_next = 1'b1;
                        heap_ok_next = 1'b1;
                        ovf_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = odc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= odc_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fifo_ok_reg   <= 1'b1;
            lifo_ok_reg   <= 1'b1;
            heap_ok_reg   <= 1'b1;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fifo_ok_reg   <= fifo_ok_next;
            lifo_ok_reg   <= lifo_ok_next;
            heap_ok_reg   <= heap_ok_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= operation;
            val_reg <= item_value;
            end_reg <= case_end;
        end
        verdict_reg  <= verdict_next;
        ovf_out_reg  <= ovf_out_next;
        done_out_reg <= done_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign overflow   = ovf_out_reg;
    assign trace_done = done_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("element count above depth");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == cell_valid[0])
        else $error("chain head valid disagrees with element count");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == odc_pkg::S_EXEC)
        else $error("accepted transaction not executed");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == odc_pkg::S_EXEC))
        else $error("result without execution");

endmodule

// ----- dv/order_discipline_checker_tb.sv -----
// Testbench for order_discipline_checker: directed and random traces checked against a predictor.
`timescale 1ns / 1ps
module order_discipline_checker_tb;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] verdict;
        logic       overflow;
        logic       trace_done;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic signed [31:0] item_value;
    logic        case_end;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  verdict;
    logic        overflow;
    logic        trace_done;

    logic signed [31:0] fifo_q[$];
    logic signed [31:0] lifo_q[$];
    logic signed [31:0] heap_q[$];
    logic        may_be_fifo;
    logic        may_be_lifo;
    logic        may_be_heap;
    logic        dropped_insert;
    outcome_t    pending_outcomes[$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left;
    bit          timed_out = 1'b0;

    order_discipline_checker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .item_value (item_value),
        .case_end   (case_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .verdict    (verdict),
        .overflow   (overflow),
        .trace_done (trace_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_trace_model();
        fifo_q.delete();
        lifo_q.delete();
        heap_q.delete();
        may_be_fifo    = 1'b1;
        may_be_lifo    = 1'b1;
        may_be_heap    = 1'b1;
        dropped_insert = 1'b0;
    endfunction

    function automatic outcome_t predict_verdict(odc_pkg::op_t op, logic signed [31:0] v,
                                                 logic done);
        outcome_t   r;
        int         alive;
        int         max_idx;
        if (op == odc_pkg::OP_INSERT)
        begin
            if (fifo_q.size() >= odc_pkg::DEPTH)
                dropped_insert = 1'b1;
            else
            begin
                fifo_q.push_back(v);
                lifo_q.push_back(v);
                heap_q.push_back(v);
            end
        end
        else if (fifo_q.size() == 0)
        begin
            may_be_fifo = 1'b0;
            may_be_lifo = 1'b0;
            may_be_heap = 1'b0;
        end
        else
        begin
            max_idx = 0;
            foreach (heap_q[i])
                if (heap_q[i] > heap_q[max_idx])
                    max_idx = i;
            if (fifo_q[0] != v)
                may_be_fifo = 1'b0;
            if (lifo_q[$] != v)
                may_be_lifo = 1'b0;
            if (heap_q[max_idx] != v)
                may_be_heap = 1'b0;
            void'(fifo_q.pop_front());
            void'(lifo_q.pop_back());
            heap_q.delete(max_idx);
        end
        alive = int'(may_be_fifo) + int'(may_be_lifo) + int'(may_be_heap);
        if (alive == 0)
            r.verdict = odc_pkg::V_IMPOSSIBLE;
        else if (alive > 1)
            r.verdict = odc_pkg::V_NOT_SURE;
        else if (may_be_fifo)
            r.verdict = odc_pkg::V_QUEUE;
        else if (may_be_lifo)
            r.verdict = odc_pkg::V_STACK;
        else
            r.verdict = odc_pkg::V_PRIORITY;
        r.overflow   = dropped_insert;
        r.trace_done = done;
        if (done)
            clear_trace_model();
        return r;
    endfunction

    task automatic send_transaction(odc_pkg::op_t op, logic signed [31:0] v, logic done);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        operation  <= op;
        item_value <= v;
        case_end   <= done;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_outcomes.push_back(predict_verdict(op, v, done));
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_transaction(odc_pkg::OP_REMOVE, 32'sd5, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, 32'sd1, 1'b1);
        send_transaction(odc_pkg::OP_INSERT, 32'sh7fffffff, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, 32'sh80000000, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, -32'sd1, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sh7fffffff, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, -32'sd1, 1'b1);
        send_transaction(odc_pkg::OP_INSERT, 32'sd3, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, 32'sd9, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd9, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd3, 1'b1);
        send_transaction(odc_pkg::OP_INSERT, 32'sd4, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, 32'sd4, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd4, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd4, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd4, 1'b1);
        send_transaction(odc_pkg::OP_INSERT, 32'sd2, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, 32'sd8, 1'b0);
        send_transaction(odc_pkg::OP_INSERT, 32'sd5, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd2, 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd8, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < odc_pkg::DEPTH + 2; i++)
            send_transaction(odc_pkg::OP_INSERT, $urandom_range(0, 7), 1'b0);
        send_transaction(odc_pkg::OP_REMOVE, 32'sd0, 1'b1);
    endtask

    task automatic test_random_traces();
        int                 len;
        int                 mode;
        int                 sent;
        logic signed [31:0] v;
        logic signed [31:0] mx;
        sent = 0;
        while (sent < 850)
        begin
            len  = $urandom_range(1, 16);
            mode = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
            begin
                if (fifo_q.size() == 0 || (fifo_q.size() < 12 && $urandom_range(0, 1)))
                begin
                    if ($urandom_range(0, 1))
                        v = $urandom_range(0, 9);
                    else
                        v = $urandom;
                    send_transaction(odc_pkg::OP_INSERT, v, 1'b0);
                end
                else
                begin
                    mx = heap_q[0];
                    foreach (heap_q[k])
                        if (heap_q[k] > mx)
                            mx = heap_q[k];
                    case (mode)
                        0: v = fifo_q[0];
                        1: v = lifo_q[$];
                        2: v = mx;
                        3: v = $urandom_range(0, 9);
                        default: v = $urandom;
                    endcase
                    send_transaction(odc_pkg::OP_REMOVE, v, 1'b0);
                end
                sent++;
            end
            send_transaction(odc_pkg::op_t'($urandom_range(0, 1)), $urandom_range(0, 9), 1'b1);
            sent++;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = 1'b0;
        item_value = '0;
        case_end   = 1'b0;
        burst_left = 0;
        clear_trace_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_overflow();
        test_random_traces();
        in_valid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0 && !timed_out)
            $display("order_discipline_checker_tb: clean");
        else
            $display("order_discipline_checker_tb: errors");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b0;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transaction: verdict %0d overflow %0d done %0d",
                             verdict, overflow, trace_done);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (want !== {verdict, overflow, trace_done})
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.verdict, want.overflow, want.trace_done,
                                 verdict, overflow, trace_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("order_discipline_checker_tb: errors");
            $finish;
        end
    end
endmodule
